// ===== src/c3f_pkg.sv =====
// c3f_pkg: shared constants, types and helpers of the 3x3 image filter
// used by every module of the block; no dependencies
`default_nettype none

package c3f_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 2048;
  localparam int COEF_FRAC_BITS = 4;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int POS_W     = 11;
  localparam int COEF_W    = 12;
  localparam int KROW_W    = 3 * COEF_W;
  localparam int CFG_IDX_W = 3;

  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  localparam int JOB_DEPTH = 8;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [DIM_W-1:0]  WIDTH_RST      = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST     = 12'd480;
  localparam logic [KROW_W-1:0] KERNEL_TOP_RST = 36'd16711680;
  localparam logic [KROW_W-1:0] KERNEL_MID_RST = 36'd68451373040;
  localparam logic [KROW_W-1:0] KERNEL_BOT_RST = 36'd16711680;

  typedef struct packed {
    logic [DIM_W-1:0]             width;
    logic [DIM_W-1:0]             height;
    logic [2:0][KROW_W-1:0]       kernel;
  } cfg_t;

  typedef struct packed {
    logic             has_int;
    logic             has_bdr;
    logic             fdone;
    logic [PIX_W-1:0] filt;
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_W'(3)) res = DIM_W'(3);
    else if (v > hi) res = hi;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/c3f_front.sv =====
// c3f_front: position counters, line buffer memory, 3x3 window and the
// pipelined multiply-accumulate; emits one classified job per request
// depends on c3f_pkg
`default_nettype none

module c3f_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire c3f_pkg::cfg_t         cfg,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_pixel,
  output c3f_pkg::job_t              job,
  output logic                       job_valid
);
  import c3f_pkg::*;

  typedef struct packed {
    logic             int_f;
    logic             bdr_f;
    logic             fdone;
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } info_t;

  logic [DIM_W-1:0] col_q, row_q;
  logic [DIM_W-1:0] col_next, row_next;
  logic [DIM_W-1:0] c_cur, r_cur, r_wrap, c_inc, r_inc, w_m1, h_m1;
  info_t            info, s1, s2, s3, s4;
  logic             s1_v, s2_v, s3_v, s4_v;

  logic [2*PIX_W-1:0] lbuf [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [8:0][PIX_W-1:0]          win;
  logic signed [PROD_W-1:0]       prod [9];
  logic signed [PSUM_W-1:0]       psum [3];
  logic signed [SUM_W-1:0]        total;
  logic [PIX_W-1:0]               filt;

  // position of this pixel, with wrap when the frame size changed
  always_comb begin
    c_cur  = col_q;
    r_wrap = row_q;
    if (col_q >= cfg.width) begin
      c_cur  = '0;
      r_wrap = row_q + 1'b1;
    end
    r_cur    = (r_wrap >= cfg.height) ? '0 : r_wrap;
    c_inc    = c_cur + 1'b1;
    r_inc    = r_cur + 1'b1;
    col_next = c_inc;
    row_next = r_cur;
    if (c_inc >= cfg.width) begin
      col_next = '0;
      row_next = (r_inc >= cfg.height) ? '0 : r_inc;
    end
  end

  assign w_m1 = cfg.width - 1'b1;
  assign h_m1 = cfg.height - 1'b1;

  always_comb begin
    info.int_f = (r_cur >= DIM_W'(2)) && (c_cur >= DIM_W'(2));
    info.bdr_f = (r_cur == '0) || (r_cur == h_m1) || (c_cur == '0) || (c_cur == w_m1);
    info.fdone = (r_cur == h_m1) && (c_cur == w_m1);
    info.pix   = in_pixel;
    info.col   = c_cur[POS_W-1:0];
    info.row   = r_cur[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      if (in_valid) begin
        col_q <= col_next;
        row_q <= row_next;
      end
    end
  end

  // line buffer entry holds {two rows up, one row up}
  always_ff @(posedge clk) begin
    if (in_valid) begin
      rd_q <= lbuf[c_cur[POS_W-1:0]];
    end
    if (s1_v) begin
      lbuf[s1.col] <= {rd_q[PIX_W-1:0], s1.pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_v) begin
      for (int rr = 0; rr < 3; rr++) begin
        win[rr*3]     <= win[rr*3 + 1];
        win[rr*3 + 1] <= win[rr*3 + 2];
      end
      win[2] <= rd_q[2*PIX_W-1:PIX_W];
      win[5] <= rd_q[PIX_W-1:0];
      win[8] <= s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) s1 <= info;
    s2 <= s1;
    s3 <= s2;
    s4 <= s3;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r*3 + c] <= $signed({1'b0, win[r*3 + c]})
                         * $signed(cfg.kernel[r][c*COEF_W +: COEF_W]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      psum[r] <= PSUM_W'(prod[r*3]) + PSUM_W'(prod[r*3 + 1]) + PSUM_W'(prod[r*3 + 2]);
    end
  end

  // clamp below zero, drop the fraction, saturate at full scale
  always_comb begin
    total = SUM_W'(psum[0]) + SUM_W'(psum[1]) + SUM_W'(psum[2]);
    if (total[SUM_W-1]) filt = '0;
    else if (|total[SUM_W-2:COEF_FRAC_BITS+PIX_W]) filt = '1;
    else filt = total[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
  end

  always_comb begin
    job.has_int = s4.int_f;
    job.has_bdr = s4.bdr_f;
    job.fdone   = s4.fdone;
    job.filt    = filt;
    job.pix     = s4.pix;
    job.col     = s4.col;
    job.row     = s4.row;
  end

  assign job_valid = s4_v;

endmodule

`default_nettype wire

// ===== src/c3f_job_fifo.sv =====
// c3f_job_fifo: short queue of classified jobs between front and back
// depends on c3f_pkg
`default_nettype none

module c3f_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire c3f_pkg::job_t push_job,
  input  wire logic          pop,
  output c3f_pkg::job_t      head_job,
  output logic               head_valid,
  output logic               fifo_full
);
  import c3f_pkg::*;

  job_t                 mem [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [JOB_CNT_W-1:0] count;
  logic                 do_push, do_pop;

  assign head_valid = (count != '0);
  assign fifo_full  = (count == JOB_CNT_W'(JOB_DEPTH));
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !fifo_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// ===== src/c3f_back.sv =====
// c3f_back: expands each job into its interior and border results and
// holds the oldest result on the output ports; depends on c3f_pkg
`default_nettype none

module c3f_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire c3f_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_pixel,
  output logic [10:0]        out_col,
  output logic [10:0]        out_row,
  output logic               last_of_run,
  output logic               frame_done
);
  import c3f_pkg::*;

  job_t cur;
  logic int_pend, bdr_pend, cur_valid, last, take;

  assign cur_valid = int_pend || bdr_pend;
  assign last      = !(int_pend && bdr_pend);
  assign take      = !cur_valid || (pop && last);
  assign job_pop   = job_valid && take;
  assign empty     = !cur_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_pend <= 1'b0;
      bdr_pend <= 1'b0;
    end else if (take) begin
      int_pend <= job_valid && job.has_int;
      bdr_pend <= job_valid && job.has_bdr;
    end else if (pop) begin
      int_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
  end

  // interior result goes first, then the border copy
  assign out_pixel   = int_pend ? cur.filt : cur.pix;
  assign out_col     = int_pend ? cur.col - 1'b1 : cur.col;
  assign out_row     = int_pend ? cur.row - 1'b1 : cur.row;
  assign last_of_run = last;
  assign frame_done  = !int_pend && cur.fdone;

endmodule

`default_nettype wire

// ===== src/conv3x3_image_filter_core.sv =====
// conv3x3_image_filter_core: top level of the streaming 3x3 image filter
// depends on c3f_pkg, c3f_front, c3f_job_fifo and c3f_back
`default_nettype none

// Accepts one 8-bit pixel per clock in raster order while full is low. Each
// pixel gives up to two results: the filtered value of the interior pixel one
// row up and one column left (when one is complete), then a copy of the pixel
// itself if it lies on the frame border. A request passes a four-stage front
// pipeline (line buffer read, window shift, nine multiplies, row sums), then
// the job queue and the output register. The front is limited by the
// single-port-read line buffer memory, one access per clock. The output side
// presents one result at a time, so a pixel with two results holds the output
// for both in turn; an eight-entry job queue absorbs this and full rises when
// accepted work not yet handed to the output stage reaches eight.
// Configuration writes take effect at once and are meant for idle periods.
module conv3x3_image_filter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    in_pixel,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         out_pixel,
  output logic [10:0]                        out_col,
  output logic [10:0]                        out_row,
  output logic                               last_of_run,
  output logic                               frame_done,
  input  wire logic                          cfg_write,
  input  wire logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [c3f_pkg::KROW_W-1:0]    cfg_data
);
  import c3f_pkg::*;

  cfg_t                 cfg;
  logic [JOB_CNT_W-1:0] credits;
  logic                 accept;
  job_t                 front_job, head_job;
  logic                 front_valid, head_valid, job_pop, fifo_full;

  assign accept = push && !full;
  assign full   = (credits == JOB_CNT_W'(JOB_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width     <= WIDTH_RST;
      cfg.height    <= HEIGHT_RST;
      cfg.kernel[0] <= KERNEL_TOP_RST;
      cfg.kernel[1] <= KERNEL_MID_RST;
      cfg.kernel[2] <= KERNEL_BOT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg.width  <= clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_WIDTH));
        REG_IMAGE_HEIGHT:  cfg.height <= clamp_dim(cfg_data[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
        REG_KERNEL_TOP:    cfg.kernel[0] <= cfg_data;
        REG_KERNEL_MID:    cfg.kernel[1] <= cfg_data;
        REG_KERNEL_BOTTOM: cfg.kernel[2] <= cfg_data;
        default:           cfg.width  <= cfg.width;
      endcase
    end
  end

  // requests accepted and not yet taken by the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      unique case ({accept, job_pop})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  c3f_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_pixel  (in_pixel),
    .job       (front_job),
    .job_valid (front_valid)
  );

  c3f_job_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_job   (front_job),
    .pop        (job_pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .fifo_full  (fifo_full)
  );

  c3f_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_valid   (head_valid),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_pixel   (out_pixel),
    .out_col     (out_col),
    .out_row     (out_row),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

`ifndef NO_ASSERTIONS
  a_no_job_loss: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> !fifo_full)
    else $error("job queue overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= JOB_CNT_W'(JOB_DEPTH))
    else $error("credit count beyond queue depth");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> last_of_run)
    else $error("frame end not on last result of its request");
`endif

endmodule

`default_nettype wire

// ===== tb/conv3x3_result_checker.sv =====
`timescale 1ns / 1ps
// conv3x3_result_checker: predicts the results of the 3x3 image filter and compares them
// watches the pixel, result and register ports of the core; depends on c3f_pkg

module conv3x3_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [7:0]                    in_pixel,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [7:0]                    out_pixel,
  input  logic [10:0]                   out_col,
  input  logic [10:0]                   out_row,
  input  logic                          last_of_run,
  input  logic                          frame_done,
  input  logic                          cfg_write,
  input  logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c3f_pkg::KROW_W-1:0]    cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);
  import c3f_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
    logic             done;
  } pixel_result_t;

  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [KROW_W-1:0] kernel_rows [3];
  logic [PIX_W-1:0]  line_above [MAX_WIDTH];
  logic [PIX_W-1:0]  line_above2 [MAX_WIDTH];
  logic [PIX_W-1:0]  window [9];
  int                col_next;
  int                row_next;
  pixel_result_t     expected_pixels [$];

  function automatic int dim_in_use(input logic [DIM_W-1:0] raw, input int hi);
    int v;
    v = int'(raw);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // nine signed Q7.4 taps, negative clips to zero, fraction dropped, top saturates
  function automatic logic [PIX_W-1:0] filtered_value();
    int                       acc;
    logic signed [COEF_W-1:0] coef;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef = kernel_rows[i][COEF_W*j +: COEF_W];
        acc += int'(window[3*i+j]) * int'(coef);
      end
    end
    if (acc < 0) return '0;
    acc = acc >> COEF_FRAC_BITS;
    if (acc > 255) return 8'hFF;
    return PIX_W'(acc);
  endfunction

  task automatic reset_model();
    width_reg      = WIDTH_RST;
    height_reg     = HEIGHT_RST;
    kernel_rows[0] = KERNEL_TOP_RST;
    kernel_rows[1] = KERNEL_MID_RST;
    kernel_rows[2] = KERNEL_BOT_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i]  = '0;
      line_above2[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    col_next = 0;
    row_next = 0;
    expected_pixels.delete();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [KROW_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT:  height_reg = data[DIM_W-1:0];
      REG_KERNEL_TOP:    kernel_rows[0] = data;
      REG_KERNEL_MID:    kernel_rows[1] = data;
      REG_KERNEL_BOTTOM: kernel_rows[2] = data;
      default: ;
    endcase
  endtask

  task automatic predict_pixel_results(input logic [PIX_W-1:0] pix);
    int            w;
    int            h;
    int            c;
    int            r;
    logic          interior;
    logic          border;
    pixel_result_t res;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, MAX_HEIGHT);
    // a shrunk size wraps the stream to the next row or the next frame
    if (col_next >= w) begin
      col_next = 0;
      row_next++;
    end
    if (row_next >= h) row_next = 0;
    c = col_next;
    r = row_next;
    for (int i = 0; i < 3; i++) begin
      window[3*i]   = window[3*i+1];
      window[3*i+1] = window[3*i+2];
    end
    window[2]      = line_above2[c];
    window[5]      = line_above[c];
    window[8]      = pix;
    line_above2[c] = line_above[c];
    line_above[c]  = pix;
    interior = (r >= 2) && (c >= 2);
    border   = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
    if (interior) begin
      res.pixel = filtered_value();
      res.col   = POS_W'(c - 1);
      res.row   = POS_W'(r - 1);
      res.last  = !border;
      res.done  = 1'b0;
      expected_pixels.push_back(res);
    end
    if (border) begin
      res.pixel = pix;
      res.col   = POS_W'(c);
      res.row   = POS_W'(r);
      res.last  = 1'b1;
      res.done  = (r == h - 1) && (c == w - 1);
      expected_pixels.push_back(res);
    end
    col_next = c + 1;
    if (col_next >= w) begin
      col_next = 0;
      row_next = r + 1;
      if (row_next >= h) row_next = 0;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] act);
    if (act !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, act);
      mismatch_count++;
    end
  endfunction

  task automatic compare_result();
    pixel_result_t exp_res;
    if (expected_pixels.size() == 0) begin
      $error("result with nothing expected: out_pixel %0d at row %0d col %0d",
             out_pixel, out_row, out_col);
      mismatch_count++;
    end else begin
      exp_res = expected_pixels.pop_front();
      check_field("out_pixel", 32'(exp_res.pixel), 32'(out_pixel));
      check_field("out_col", 32'(exp_res.col), 32'(out_col));
      check_field("out_row", 32'(exp_res.row), 32'(out_row));
      check_field("last_of_run", 32'(exp_res.last), 32'(last_of_run));
      check_field("frame_done", 32'(exp_res.done), 32'(frame_done));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      mismatch_count = 0;
    end else begin
      if (cfg_write) write_register(cfg_index, cfg_data);
      if (push && !full) predict_pixel_results(in_pixel);
      if (pop && !empty) compare_result();
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== tb/conv3x3_image_filter_core_test.sv =====
`timescale 1ns / 1ps
// conv3x3_image_filter_core_test: stimulus and verdict for the 3x3 image filter core
// depends on c3f_pkg, conv3x3_image_filter_core and conv3x3_result_checker

module conv3x3_image_filter_core_test;
  import c3f_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int WIDE_PIXELS   = 32;
  localparam int NARROW_PIXELS = 15;
  localparam int RANDOM_PIXELS = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_pixel = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_pixel;
  logic [10:0]          out_col;
  logic [10:0]          out_row;
  logic                 last_of_run;
  logic                 frame_done;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [KROW_W-1:0]    cfg_data = '0;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int pos_col = 0;
  int pos_row = 0;
  int cur_w = 640;
  int cur_h = 480;
  int random_pixels = 0;

  always #5 clk = ~clk;

  conv3x3_image_filter_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_pixel    (in_pixel),
    .empty       (empty),
    .pop         (pop),
    .out_pixel   (out_pixel),
    .out_col     (out_col),
    .out_row     (out_row),
    .last_of_run (last_of_run),
    .frame_done  (frame_done),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  conv3x3_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_pixel       (in_pixel),
    .empty          (empty),
    .pop            (pop),
    .out_pixel      (out_pixel),
    .out_col        (out_col),
    .out_row        (out_row),
    .last_of_run    (last_of_run),
    .frame_done     (frame_done),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random idling, plus long holds counted here
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= !(idle_on && $urandom_range(99) < 31);
    end
  end

  function automatic int dim_in_use(input logic [DIM_W-1:0] raw);
    if (raw < 3) return 3;
    if (int'(raw) > MAX_WIDTH) return MAX_WIDTH;
    return int'(raw);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(5))
      0:       return 12'h7FF;
      1:       return 12'h800;
      2:       return 12'h000;
      3:       return 12'hFFF;
      4:       return 12'($urandom);
      default: return 12'($urandom_range(64) - 32);
    endcase
  endfunction

  function automatic int pixels_to_frame_end();
    int c;
    int r;
    c = pos_col;
    r = pos_row;
    if (c >= cur_w) begin
      c = 0;
      r++;
    end
    if (r >= cur_h) r = 0;
    return cur_w * cur_h - (r * cur_w + c);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [KROW_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == REG_IMAGE_WIDTH) cur_w = dim_in_use(data[DIM_W-1:0]);
    else if (idx == REG_IMAGE_HEIGHT) cur_h = dim_in_use(data[DIM_W-1:0]);
  endtask

  // upper data bits carry junk, only the low twelve count
  task automatic set_size(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
    write_reg(REG_IMAGE_WIDTH, {24'($urandom), w_raw});
    write_reg(REG_IMAGE_HEIGHT, {24'($urandom), h_raw});
  endtask

  task automatic write_random_kernel();
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(1) == 1)
        write_reg(CFG_IDX_W'(REG_KERNEL_TOP + k), {random_coef(), random_coef(), random_coef()});
    end
  endtask

  // one pixel request, position tracked so that sizes only grow at a frame start
  task automatic send_pixel(input logic [7:0] pix);
    while (idle_on && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (pos_col >= cur_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= cur_h) pos_row = 0;
    pos_col++;
    if (pos_col >= cur_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= cur_h) pos_row = 0;
    end
  endtask

  task automatic send_run(input int count, input bit alternating);
    for (int k = 0; k < count; k++)
      send_pixel(alternating ? (k[0] ? 8'hFF : 8'h00) : pick_pixel());
    push <= 1'b0;
  endtask

  task automatic settle();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int               run_len;
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes and sharpen kernel: part of a wide first row, then a narrower
    // frame picked up mid-row, alternating black and white to hit both clips
    send_run(12, 1'b1);
    settle();
    set_size(12'd5, 12'd4);
    send_run(pixels_to_frame_end(), 1'b1);
    settle();

    // unused register slots
    for (int k = int'(REG_UNUSED_FIRST); k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), '1);

    // widest line and shortest frame, both clamped: opening columns, no idling
    idle_on = 1'b0;
    set_size(12'hFFF, 12'd1);
    send_run(WIDE_PIXELS, 1'b0);
    settle();
    idle_on = 1'b1;

    // narrowest line, tallest frame, steepest taps
    write_reg(REG_KERNEL_TOP, {3{12'h7FF}});
    write_reg(REG_KERNEL_MID, {3{12'h800}});
    write_reg(REG_KERNEL_BOTTOM, '1);
    set_size(12'd0, 12'd2048);
    send_run(NARROW_PIXELS, 1'b0);
    settle();

    // output held off while a whole frame streams in
    write_random_kernel();
    set_size(12'd6, 12'd6);
    hold_requests = hold_requests + 1;
    send_run(pixels_to_frame_end(), 1'b0);
    settle();

    // random frames: mostly complete, some cut short and shrunk mid-frame
    while (random_pixels < RANDOM_PIXELS) begin
      write_random_kernel();
      if (pos_col == 0 && pos_row == 0) begin
        w_raw = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(2))
                                         : DIM_W'($urandom_range(3, 9));
        h_raw = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(2))
                                         : DIM_W'($urandom_range(3, 7));
        set_size(w_raw, h_raw);
      end else if ($urandom_range(2) == 0) begin
        set_size(DIM_W'($urandom_range(3, cur_w)), DIM_W'($urandom_range(3, cur_h)));
      end
      run_len = pixels_to_frame_end();
      if ($urandom_range(3) == 0) run_len = $urandom_range(1, run_len);
      if (run_len > RANDOM_PIXELS - random_pixels)
        run_len = RANDOM_PIXELS - random_pixels;
      send_run(run_len, 1'b0);
      random_pixels += run_len;
      settle();
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/c3f_pkg.sv
src/c3f_front.sv
src/c3f_job_fifo.sv
src/c3f_back.sv
src/conv3x3_image_filter_core.sv
tb/conv3x3_result_checker.sv
tb/conv3x3_image_filter_core_test.sv
